[src/slot_collision_backoff_core_assert.svh]
// assertion macros used by slot_collision_backoff_core
`ifndef SLOT_COLLISION_BACKOFF_CORE_ASSERT_SVH
`define SLOT_COLLISION_BACKOFF_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SBC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sbc_pkg.sv]
package sbc_pkg;

  // sizes of the contention model
  localparam int unsigned DEVICES    = 5;
  localparam int unsigned SLOT_BITS  = 16;
  localparam int unsigned SLICE_BITS = 12;
  localparam int unsigned CNT_W      = $clog2(DEVICES + 1);
  localparam int unsigned EXP_W      = 4;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned RND_W      = 60;

  localparam logic [EXP_W-1:0]     LIMIT_CAP   = EXP_W'(10);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(10);
  localparam logic [SLOT_BITS-1:0] SLOT_MAX    = '1;

  // configuration port
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BACKOFF_LIMIT = REG_IDX_W'(0);

  // item operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic             op;
    logic [RND_W-1:0] random_word;
  } sbc_in_t;

  typedef struct packed {
    logic [15:0] slot;
    logic [2:0]  senders;
    logic        collision;
    logic        run_done;
    logic        overflow;
    logic [3:0]  collisions_so_far;
  } sbc_out_t;

endpackage

[src/sbc_cfg_regs.sv]
module sbc_cfg_regs import sbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [EXP_W-1:0]  limit_o
);

  logic [LIMIT_W-1:0]   limit_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_BACKOFF_LIMIT);

  // backoff limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      REG_BACKOFF_LIMIT: prdata = DATA_W'(limit_q);
      default:           prdata = '0;
    endcase
  end

  // limits above the cap behave as the cap
  assign limit_o = (EXP_W'(limit_q) > LIMIT_CAP) ? LIMIT_CAP : EXP_W'(limit_q);

endmodule

[src/slot_collision_backoff_core.sv]
// an accepted beat is held in the input register, then evaluated into the result register,
//   which drives out_valid_o until the result beat is taken
// throughput: one item per cycle while out_stall_i does not hold the result register, with
//   a combinational slot evaluation between the input register and the result register
// reset: clears schedules, slot counter, exponent and the valid bits of both pipeline registers;
//   the backoff limit register returns to 10
module slot_collision_backoff_core import sbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbc_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

`include "slot_collision_backoff_core_assert.svh"

  logic                 in_valid_q;
  sbc_in_t              in_q;
  logic                 out_valid_q;
  sbc_out_t             out_q;
  logic [SLOT_BITS-1:0] sched_q [DEVICES];
  logic [SLOT_BITS-1:0] sched_d [DEVICES];
  logic [SLOT_BITS-1:0] cur_q, cur_d;
  logic [EXP_W-1:0]     exp_q, exp_d;
  logic [EXP_W-1:0]     limit;

  logic                  adv, fire;
  logic [DEVICES-1:0]    match;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic                  coll;
  logic [EXP_W-1:0]      mask_exp;
  logic [SLICE_BITS:0]   one_sh;
  logic [SLICE_BITS-1:0] mask;
  logic [SLOT_BITS:0]    sum [DEVICES];
  logic [SLOT_BITS-1:0]  cur_inc;
  logic [EXP_W-1:0]      exp_inc;
  sbc_out_t              res;

  sbc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // handshake: result register frees up when empty or taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // per-device compare and backoff reschedule
  always_comb begin
    done  = 1'b1;
    count = '0;
    for (int i = 0; i < DEVICES; i++) begin
      match[i] = (sched_q[i] == cur_q);
      if (sched_q[i] >= cur_q) begin
        done = 1'b0;
      end
      count = count + CNT_W'(match[i]);
    end
    coll     = (count > CNT_W'(1));
    mask_exp = (exp_q < limit) ? exp_q : limit;
    one_sh   = (SLICE_BITS + 1)'(1) << mask_exp;
    mask     = SLICE_BITS'(one_sh - 1'b1);
    for (int i = 0; i < DEVICES; i++) begin
      sum[i] = {1'b0, cur_q} + (SLOT_BITS + 1)'(1)
             + (SLOT_BITS + 1)'(in_q.random_word[i*SLICE_BITS +: SLICE_BITS] & mask);
    end
  end

  // next state and result for the item in the input register
  always_comb begin
    cur_inc = (cur_q != SLOT_MAX) ? SLOT_BITS'(cur_q + 1'b1) : cur_q;
    exp_inc = (exp_q < limit) ? EXP_W'(exp_q + 1'b1) : exp_q;
    cur_d   = cur_q;
    exp_d   = exp_q;
    for (int i = 0; i < DEVICES; i++) begin
      sched_d[i] = sched_q[i];
    end
    res = '0;
    if (in_q.op == OP_RESTART) begin
      cur_d = '0;
      exp_d = '0;
      for (int i = 0; i < DEVICES; i++) begin
        sched_d[i] = '0;
      end
    end else if (done) begin
      res.slot              = 16'(cur_q);
      res.run_done          = 1'b1;
      res.overflow          = (cur_q == SLOT_MAX);
      res.collisions_so_far = 4'(exp_q);
    end else begin
      if (coll) begin
        exp_d = exp_inc;
        for (int i = 0; i < DEVICES; i++) begin
          if (match[i]) begin
            sched_d[i] = sum[i][SLOT_BITS] ? SLOT_MAX : sum[i][SLOT_BITS-1:0];
          end
        end
      end
      cur_d                 = cur_inc;
      res.slot              = 16'(cur_q);
      res.senders           = 3'(count);
      res.collision         = coll;
      res.overflow          = (cur_inc == SLOT_MAX);
      res.collisions_so_far = 4'(exp_d);
    end
  end

  // contention state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      exp_q <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        sched_q[i] <= '0;
      end
    end else if (fire) begin
      cur_q <= cur_d;
      exp_q <= exp_d;
      for (int i = 0; i < DEVICES; i++) begin
        sched_q[i] <= sched_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `SBC_ASSERT_NOW(a_exp_capped, 1'b1, exp_q <= LIMIT_CAP, "collision exponent above cap")
  `SBC_ASSERT_NOW(a_stall_needs_item, in_stall_o, in_valid_q, "stall with empty input register")
  `SBC_ASSERT_NOW(a_coll_senders, out_valid_q,
                  out_q.collision == (out_q.senders > 3'd1),
                  "collision flag disagrees with senders")
  `SBC_ASSERT_NEXT(a_restart_clears, fire && (in_q.op == OP_RESTART),
                   (cur_q == '0) && (exp_q == '0), "restart left state behind")
  `SBC_ASSERT_NEXT(a_slot_monotonic, fire && (in_q.op == OP_TICK),
                   cur_q >= $past(cur_q), "slot counter moved back on a tick")

endmodule
